// ===== src/scaled_glyph_row_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scaled glyph row generator
// Simulation-only property checks; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_ROW_GENERATOR_CORE_DEFINES_SVH
`define SCALED_GLYPH_ROW_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SGRG_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("sgrg: same-cycle check failed");
// next-cycle implication
`define SGRG_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("sgrg: next-cycle check failed");
`else
`define SGRG_ASSERT_IMP(lbl, ck, rn, pre, post)
`define SGRG_ASSERT_NXT(lbl, ck, rn, pre, post)
`endif
`endif

// ===== src/sgrg_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrg_pkg
// Shared types, constants and the 5x7 font table of the glyph row generator.
// ----------------------------------------------------------------------------
package sgrg_pkg;

  // cell geometry
  localparam int CELL_WIDTH    = 6;
  localparam int CELL_HEIGHT   = 8;
  localparam int MAX_SCALE_DEF = 8;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int GROW_W        = $clog2(CELL_HEIGHT);

  // character range covered by the font
  localparam logic [7:0] FIRST_CODE   = 8'h20;
  localparam logic [7:0] LAST_CODE    = 8'h7E;
  localparam logic [6:0] SOLID_COLUMN = 7'h7F;
  localparam int         FONT_CHARS   = 95;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register map (index = paddr[4:2])
  localparam logic [2:0] REG_FG_COLOR      = 3'd0;
  localparam logic [2:0] REG_BG_COLOR      = 3'd1;
  localparam logic [2:0] REG_PIXEL_SCALE   = 3'd2;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;
  localparam int         CFG_ADDR_W        = 5;

  // register reset values
  localparam logic [15:0] FG_COLOR_RST      = 16'hFFFF;
  localparam logic [15:0] BG_COLOR_RST      = 16'h0000;
  localparam logic [7:0]  PIXEL_SCALE_RST   = 8'd1;
  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd240;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd320;

  // five glyph columns, seven rows each, bit 0 = top row
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  // one classified request waiting for the row emitter
  typedef struct packed {
    logic [11:0] cell_x;
    logic [11:0] cell_y;
    glyph_t      glyph;
    logic        rejected;
  } job_t;

  // one entry per character, columns 0..4 from the top byte down
  localparam logic [39:0] FONT_ROM [FONT_CHARS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0804081008
  };

  // glyph for a character byte; unmapped codes give the solid block
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t      g;
    logic [39:0] ent;
    logic [6:0]  idx;
    idx = 7'(code - FIRST_CODE);
    ent = '0;
    if (code inside {[FIRST_CODE:LAST_CODE]}) begin
      ent = FONT_ROM[idx];
      for (int c = 0; c < GLYPH_COLS; c++) begin
        g[c] = ent[39 - 8*c - 1 -: GLYPH_ROWS];
      end
    end else begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        g[c] = SOLID_COLUMN;
      end
    end
    return g;
  endfunction

endpackage

// ===== src/sgrg_front.sv =====
// ----------------------------------------------------------------------------
// sgrg_front
// Accepts character requests, looks up the glyph and rejects a cell that does not fit on the screen.
// ----------------------------------------------------------------------------
module sgrg_front #(
  parameter int MAX_SCALE = sgrg_pkg::MAX_SCALE_DEF,
  parameter int SCALE_W   = $clog2(MAX_SCALE + 1)
) (
  input  logic                 start,
  input  logic                 q_full,
  input  logic [7:0]           in_char_code,
  input  logic [11:0]          in_cell_x,
  input  logic [11:0]          in_cell_y,
  input  logic [SCALE_W-1:0]   scale,
  input  logic [11:0]          screen_width,
  input  logic [11:0]          screen_height,
  output logic                 push,
  output sgrg_pkg::job_t       job
);

  logic [12:0] x_end;
  logic [12:0] y_end;

  // far edges of the scaled cell
  always_comb begin
    x_end = 13'(in_cell_x) + 13'(sgrg_pkg::CELL_WIDTH) * 13'(scale);
    y_end = 13'(in_cell_y) + 13'(sgrg_pkg::CELL_HEIGHT) * 13'(scale);
  end

  // classify and hand to the queue
  always_comb begin
    push         = start && !q_full;
    job.cell_x   = in_cell_x;
    job.cell_y   = in_cell_y;
    job.glyph    = sgrg_pkg::glyph_lookup(in_char_code);
    job.rejected = (x_end > 13'(screen_width)) || (y_end > 13'(screen_height));
  end

endmodule

// ===== src/sgrg_queue.sv =====
// ----------------------------------------------------------------------------
// sgrg_queue
// Short FIFO of classified requests between the front and the row emitter.
// ----------------------------------------------------------------------------
module sgrg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sgrg_pkg::job_t push_job,
  input  logic           pop,
  output sgrg_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (sgrg_pkg::QUEUE_DEPTH > 1) ? $clog2(sgrg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sgrg_pkg::QUEUE_DEPTH + 1);

  sgrg_pkg::job_t   mem_r [sgrg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(sgrg_pkg::QUEUE_DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(sgrg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(sgrg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/sgrg_back.sv =====
// ----------------------------------------------------------------------------
// sgrg_back
// Row emitter: walks the scaled rows of the head request, one per cycle.
// ----------------------------------------------------------------------------
module sgrg_back #(
  parameter int MAX_SCALE = sgrg_pkg::MAX_SCALE_DEF,
  parameter int SCALE_W   = $clog2(MAX_SCALE + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sgrg_pkg::job_t       job,
  input  logic                 empty,
  input  logic [SCALE_W-1:0]   scale,
  input  logic [15:0]          fg_color,
  input  logic [15:0]          bg_color,
  output logic                 pop,
  output logic                 out_valid,
  output logic [11:0]          out_row_y,
  output logic [11:0]          out_start_x,
  output logic [15:0]          out_color_col0,
  output logic [15:0]          out_color_col1,
  output logic [15:0]          out_color_col2,
  output logic [15:0]          out_color_col3,
  output logic [15:0]          out_color_col4,
  output logic [15:0]          out_color_col5,
  output logic [3:0]           out_repeat_count,
  output logic                 out_last_row,
  output logic                 out_rejected
);

  localparam int ROW_W  = $clog2(sgrg_pkg::CELL_HEIGHT * MAX_SCALE);
  localparam int GROW_W = sgrg_pkg::GROW_W;

  // row counters: sub-row within a glyph row, glyph row, screen row offset
  logic [SCALE_W-1:0] sub_r, sub_nxt;
  logic [GROW_W-1:0]  grow_r, grow_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic               sub_wrap;
  logic               last;
  logic [7:0]         col_ext [sgrg_pkg::GLYPH_COLS];
  logic [15:0]        color   [sgrg_pkg::GLYPH_COLS];

  logic               valid_r, valid_nxt;
  logic [11:0]        row_y_r, row_y_nxt;
  logic [11:0]        start_x_r, start_x_nxt;
  logic [15:0]        col_r [sgrg_pkg::CELL_WIDTH];
  logic [15:0]        col_nxt [sgrg_pkg::CELL_WIDTH];
  logic [3:0]         repeat_r, repeat_nxt;
  logic               last_r, last_nxt;
  logic               rej_r, rej_nxt;

  // end of the current request
  always_comb begin
    sub_wrap = (sub_r == SCALE_W'(scale - 1'b1));
    last     = job.rejected ||
               (sub_wrap && grow_r == GROW_W'(sgrg_pkg::CELL_HEIGHT - 1));
    pop      = !empty && last;
  end

  // counter advance
  always_comb begin
    sub_nxt  = sub_r;
    grow_nxt = grow_r;
    row_nxt  = row_r;
    if (!empty) begin
      if (last) begin
        sub_nxt  = '0;
        grow_nxt = '0;
        row_nxt  = '0;
      end else begin
        row_nxt = row_r + 1'b1;
        if (sub_wrap) begin
          sub_nxt  = '0;
          grow_nxt = grow_r + 1'b1;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
    end
  end

  // pixel colors of the current glyph row; the gutter row reads the pad bit
  always_comb begin
    for (int c = 0; c < sgrg_pkg::GLYPH_COLS; c++) begin
      col_ext[c] = {1'b0, job.glyph[c]};
      color[c]   = col_ext[c][grow_r] ? fg_color : bg_color;
    end
  end

  // next result
  always_comb begin
    valid_nxt  = !empty;
    repeat_nxt = 4'(scale);
    last_nxt   = 1'b1;
    rej_nxt    = job.rejected;
    if (job.rejected) begin
      row_y_nxt   = '0;
      start_x_nxt = '0;
      for (int c = 0; c < sgrg_pkg::CELL_WIDTH; c++) begin
        col_nxt[c] = '0;
      end
    end else begin
      row_y_nxt   = job.cell_y + 12'(row_r);
      start_x_nxt = job.cell_x;
      last_nxt    = last;
      for (int c = 0; c < sgrg_pkg::GLYPH_COLS; c++) begin
        col_nxt[c] = color[c];
      end
      col_nxt[sgrg_pkg::CELL_WIDTH-1] = bg_color;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= '0;
      grow_r  <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sub_r   <= sub_nxt;
      grow_r  <= grow_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    row_y_r   <= row_y_nxt;
    start_x_r <= start_x_nxt;
    repeat_r  <= repeat_nxt;
    last_r    <= last_nxt;
    rej_r     <= rej_nxt;
    for (int c = 0; c < sgrg_pkg::CELL_WIDTH; c++) begin
      col_r[c] <= col_nxt[c];
    end
  end

  assign out_valid        = valid_r;
  assign out_row_y        = row_y_r;
  assign out_start_x      = start_x_r;
  assign out_color_col0   = col_r[0];
  assign out_color_col1   = col_r[1];
  assign out_color_col2   = col_r[2];
  assign out_color_col3   = col_r[3];
  assign out_color_col4   = col_r[4];
  assign out_color_col5   = col_r[5];
  assign out_repeat_count = repeat_r;
  assign out_last_row     = last_r;
  assign out_rejected     = rej_r;

endmodule

// ===== src/scaled_glyph_row_generator_core.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_row_generator_core
// Expands character requests into scaled rows of 6x8 font cell pixel colors.
// ----------------------------------------------------------------------------
// A taken request is held in the request queue, and its first row result in the back end's result registers.
// Throughput: one row per cycle, 8*scale rows per request (one if rejected),
//   paced by the row counter of the back end; a two-deep request queue lets
//   a new request be taken while rows of earlier ones are still going out.
// Results cannot be stalled. Reset empties the queue, drops any pending
//   rows and restores the register defaults.
`include "scaled_glyph_row_generator_core_defines.svh"

module scaled_glyph_row_generator_core #(
  parameter int MAX_SCALE = sgrg_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sgrg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        in_char_code,
  input  logic [11:0]                       in_cell_x,
  input  logic [11:0]                       in_cell_y,
  // result channel
  output logic                              out_valid,
  output logic [11:0]                       out_row_y,
  output logic [11:0]                       out_start_x,
  output logic [15:0]                       out_color_col0,
  output logic [15:0]                       out_color_col1,
  output logic [15:0]                       out_color_col2,
  output logic [15:0]                       out_color_col3,
  output logic [15:0]                       out_color_col4,
  output logic [15:0]                       out_color_col5,
  output logic [3:0]                        out_repeat_count,
  output logic                              out_last_row,
  output logic                              out_rejected
);

  localparam int SCALE_W = $clog2(MAX_SCALE + 1);

  logic [15:0]        fg_color_r, fg_color_nxt;
  logic [15:0]        bg_color_r, bg_color_nxt;
  logic [7:0]         pixel_scale_r, pixel_scale_nxt;
  logic [11:0]        screen_width_r, screen_width_nxt;
  logic [11:0]        screen_height_r, screen_height_nxt;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic [SCALE_W-1:0] scale;

  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  sgrg_pkg::job_t     push_job;
  sgrg_pkg::job_t     head_job;

  // register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    fg_color_nxt      = fg_color_r;
    bg_color_nxt      = bg_color_r;
    pixel_scale_nxt   = pixel_scale_r;
    screen_width_nxt  = screen_width_r;
    screen_height_nxt = screen_height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        sgrg_pkg::REG_FG_COLOR:      fg_color_nxt      = pwdata[15:0];
        sgrg_pkg::REG_BG_COLOR:      bg_color_nxt      = pwdata[15:0];
        sgrg_pkg::REG_PIXEL_SCALE:   pixel_scale_nxt   = pwdata[7:0];
        sgrg_pkg::REG_SCREEN_WIDTH:  screen_width_nxt  = pwdata[11:0];
        sgrg_pkg::REG_SCREEN_HEIGHT: screen_height_nxt = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r      <= sgrg_pkg::FG_COLOR_RST;
      bg_color_r      <= sgrg_pkg::BG_COLOR_RST;
      pixel_scale_r   <= sgrg_pkg::PIXEL_SCALE_RST;
      screen_width_r  <= sgrg_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= sgrg_pkg::SCREEN_HEIGHT_RST;
    end else begin
      fg_color_r      <= fg_color_nxt;
      bg_color_r      <= bg_color_nxt;
      pixel_scale_r   <= pixel_scale_nxt;
      screen_width_r  <= screen_width_nxt;
      screen_height_r <= screen_height_nxt;
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      sgrg_pkg::REG_FG_COLOR:      prdata = 32'(fg_color_r);
      sgrg_pkg::REG_BG_COLOR:      prdata = 32'(bg_color_r);
      sgrg_pkg::REG_PIXEL_SCALE:   prdata = 32'(pixel_scale_r);
      sgrg_pkg::REG_SCREEN_WIDTH:  prdata = 32'(screen_width_r);
      sgrg_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_r);
      default:                     prdata = '0;
    endcase
  end

  // effective scale, clamped to 1..MAX_SCALE
  always_comb begin
    if (pixel_scale_r == '0) begin
      scale = SCALE_W'(1);
    end else if (pixel_scale_r > 8'(MAX_SCALE)) begin
      scale = SCALE_W'(MAX_SCALE);
    end else begin
      scale = SCALE_W'(pixel_scale_r);
    end
  end

  assign busy = q_full;

  sgrg_front #(
    .MAX_SCALE (MAX_SCALE),
    .SCALE_W   (SCALE_W)
  ) u_front (
    .start         (start),
    .q_full        (q_full),
    .in_char_code  (in_char_code),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .scale         (scale),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .push          (push),
    .job           (push_job)
  );

  sgrg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  sgrg_back #(
    .MAX_SCALE (MAX_SCALE),
    .SCALE_W   (SCALE_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job              (head_job),
    .empty            (q_empty),
    .scale            (scale),
    .fg_color         (fg_color_r),
    .bg_color         (bg_color_r),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_row_y        (out_row_y),
    .out_start_x      (out_start_x),
    .out_color_col0   (out_color_col0),
    .out_color_col1   (out_color_col1),
    .out_color_col2   (out_color_col2),
    .out_color_col3   (out_color_col3),
    .out_color_col4   (out_color_col4),
    .out_color_col5   (out_color_col5),
    .out_repeat_count (out_repeat_count),
    .out_last_row     (out_last_row),
    .out_rejected     (out_rejected)
  );

  // a taken request is queued for the emitter
  `SGRG_ASSERT_NXT(a_push_queued, clk, rst_n, push, !q_empty)
  // a pending request always drives a result in the next cycle
  `SGRG_ASSERT_NXT(a_emit_pending, clk, rst_n, !q_empty, out_valid)
  // a rejected cell is a single closing result with no position
  `SGRG_ASSERT_IMP(a_reject_form, clk, rst_n, out_valid && out_rejected, out_last_row && out_row_y == '0 && out_start_x == '0)
  // the queue is only popped when it holds something
  `SGRG_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !q_empty)

endmodule
